/* design/ibus_channel_frame_encoder_macros.svh */
// Assertion macros used by the encoder design file.
`ifndef IBUS_CHANNEL_FRAME_ENCODER_MACROS_SVH
`define IBUS_CHANNEL_FRAME_ENCODER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IBCFE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define IBCFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* design/ibcfe_pkg.sv */
package ibcfe_pkg;

  localparam int CHANNELS  = 14;
  localparam int VAL_W     = 11;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int POS_W     = 4;
  localparam int DIV_CNT_W = 4;

  localparam logic [7:0]       HDR_LO    = 8'h20;
  localparam logic [7:0]       HDR_HI    = 8'h40;
  localparam logic [15:0]      HDR_WORD  = 16'h4020;
  localparam logic [15:0]      SUM_START = 16'hFFFF;
  localparam logic [15:0]      SUM_RESET = SUM_START - {8'h00, HDR_WORD[7:0]}
                                           - {8'h00, HDR_WORD[15:8]};
  localparam logic [VAL_W-1:0] OUT_MIN   = 11'd1000;
  localparam logic [VAL_W-1:0] OUT_MAX   = 11'd2000;
  // Doubled output span and doubled offset plus one give round to nearest.
  localparam logic [VAL_W-1:0] MUL_K     = 11'(2 * (OUT_MAX - OUT_MIN));
  localparam logic [VAL_W:0]   ROUND_K   = 12'(2 * OUT_MIN + 1);

  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(CHANNELS - 1);

  // Register indexes on the configuration port.
  localparam logic REG_IN_MIN = 1'b0;
  localparam logic REG_IN_MAX = 1'b1;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* design/ibcfe_div.sv */
// Restoring divider, one quotient bit per cycle. The dividend is known to be
// below divisor * 2**VAL_W, so VAL_W steps give the whole quotient.
module ibcfe_div import ibcfe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  div_ctrl_t         ctrl,
  input  logic [PROD_W-1:0] dividend,
  input  logic [VAL_W-1:0]  divisor,
  output div_stat_t         stat,
  output logic [VAL_W-1:0]  quotient
);

  logic [VAL_W-1:0]     rem_r;
  logic [VAL_W-1:0]     acc_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [VAL_W:0] shifted;
  logic [VAL_W:0] trial;
  logic           ge;

  assign shifted = {rem_r, acc_r[VAL_W-1]};
  assign ge      = (shifted >= {1'b0, divisor});
  assign trial   = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctrl.start) begin
      rem_r  <= dividend[PROD_W-1:VAL_W];
      acc_r  <= dividend[VAL_W-1:0];
      cnt_r  <= '0;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= ge ? trial[VAL_W-1:0] : shifted[VAL_W-1:0];
      acc_r <= {acc_r[VAL_W-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(VAL_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = acc_r;

endmodule

/* design/ibus_channel_frame_encoder.sv */
// An input transfer reaches its first output byte through the multiply, the divider
// start, 11 divider steps and the result register; an empty or inverted range skips
// the divider. The block takes no new channel item until every byte of the current
// one (2 or 4 bytes) has been transferred; the iterative divider limits the rate.
// Reset: synchronous, active low; clears the frame position and handshakes,
// presets the checksum to SUM_RESET, and loads in_min = 172 and in_max = 1811.
`include "ibus_channel_frame_encoder_macros.svh"

module ibus_channel_frame_encoder import ibcfe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // Input channel: one raw channel value per transfer.
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [VAL_W-1:0] in_channel_value,
  // Result channel: the frame as a byte stream.
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last_byte,
  // Configuration port.
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // The sequencer walks each item through the multiplier, the shared divider
  // and then the byte emitter. The block takes no new item until the last
  // byte of the current one has been transferred.
  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_EMIT
  } state_t;

  // Byte slots of one item, in the order in which they leave the block.
  typedef enum logic [2:0] {
    B_HDR_LO,
    B_HDR_HI,
    B_VAL_LO,
    B_VAL_HI,
    B_CS_LO,
    B_CS_HI
  } byte_sel_t;

  state_t           state_r,    state_nxt;
  logic [POS_W-1:0] pos_r,      pos_nxt;
  logic [15:0]      csum_r,     csum_nxt;
  logic [VAL_W-1:0] in_min_r,   in_min_nxt;
  logic [VAL_W-1:0] in_max_r,   in_max_nxt;
  logic [VAL_W-1:0] d_r,        d_nxt;
  logic             zero_r,     zero_nxt;
  logic [PROD_W-1:0] prod_r,    prod_nxt;
  logic             div_start_r, div_start_nxt;
  logic [VAL_W-1:0] word_r,     word_nxt;
  logic [15:0]      sum_r,      sum_nxt;
  byte_sel_t        step_r,     step_nxt;
  byte_sel_t        end_step_r, end_step_nxt;
  logic             out_valid_r, out_valid_nxt;

  div_ctrl_t        div_ctrl;
  div_stat_t        div_stat;
  logic [VAL_W-1:0] quotient;

  logic             cfg_wr;
  logic [VAL_W-1:0] clamped;
  logic [VAL_W:0]   rounded;
  logic [VAL_W-1:0] word_calc;
  logic             first_ch;
  logic             last_ch;

  // The divider sees the span as its divisor; the dividend is the scaled offset.
  assign div_ctrl.start = div_start_r;

  ibcfe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (prod_r),
    .divisor  (in_max_r - in_min_r),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Configuration writes complete in the access phase; pready never stalls.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_IN_MAX) ? {21'd0, in_max_r} : {21'd0, in_min_r};

  // Clamp the incoming value to the configured range.
  always_comb begin
    if (in_channel_value < in_min_r) begin
      clamped = in_min_r;
    end else if (in_channel_value > in_max_r) begin
      clamped = in_max_r;
    end else begin
      clamped = in_channel_value;
    end
  end

  // Halving the doubled quotient plus the doubled offset rounds to nearest.
  assign rounded   = {1'b0, quotient} + ROUND_K;
  assign word_calc = zero_r ? OUT_MIN : rounded[VAL_W:1];

  assign first_ch = (pos_r == '0);
  assign last_ch  = (pos_r >= POS_LAST);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    csum_nxt      = csum_r;
    in_min_nxt    = in_min_r;
    in_max_nxt    = in_max_r;
    d_nxt         = d_r;
    zero_nxt      = zero_r;
    prod_nxt      = prod_r;
    div_start_nxt = 1'b0;
    word_nxt      = word_r;
    sum_nxt       = sum_r;
    step_nxt      = step_r;
    end_step_nxt  = end_step_r;
    out_valid_nxt = out_valid_r;

    if (cfg_wr) begin
      if (paddr[2] == REG_IN_MIN) begin
        in_min_nxt = pwdata[VAL_W-1:0];
      end else begin
        in_max_nxt = pwdata[VAL_W-1:0];
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          d_nxt     = clamped - in_min_r;
          zero_nxt  = (in_max_r <= in_min_r);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt      = PROD_W'(d_r) * PROD_W'(MUL_K);
        div_start_nxt = !zero_r;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (zero_r || div_stat.done) begin
          word_nxt      = word_calc;
          sum_nxt       = csum_r - {8'd0, word_calc[7:0]}
                          - {13'd0, word_calc[VAL_W-1:8]};
          step_nxt      = first_ch ? B_HDR_LO : B_VAL_LO;
          end_step_nxt  = last_ch ? B_CS_HI : B_VAL_HI;
          out_valid_nxt = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          if (step_r == end_step_r) begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_IDLE;
            // The frame closes after the checksum bytes have gone out.
            if (last_ch) begin
              pos_nxt  = '0;
              csum_nxt = SUM_RESET;
            end else begin
              pos_nxt  = pos_r + 1'b1;
              csum_nxt = sum_r;
            end
          end else begin
            unique case (step_r)
              B_HDR_LO: step_nxt = B_HDR_HI;
              B_HDR_HI: step_nxt = B_VAL_LO;
              B_VAL_LO: step_nxt = B_VAL_HI;
              B_VAL_HI: step_nxt = B_CS_LO;
              B_CS_LO:  step_nxt = B_CS_HI;
              default:  step_nxt = B_CS_HI;
            endcase
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      csum_r      <= SUM_RESET;
      in_min_r    <= 11'd172;
      in_max_r    <= 11'd1811;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      csum_r      <= csum_nxt;
      in_min_r    <= in_min_nxt;
      in_max_r    <= in_max_nxt;
      div_start_r <= div_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    d_r        <= d_nxt;
    zero_r     <= zero_nxt;
    prod_r     <= prod_nxt;
    word_r     <= word_nxt;
    sum_r      <= sum_nxt;
    step_r     <= step_nxt;
    end_step_r <= end_step_nxt;
  end

  // Output byte selected from the header constants, the held word and the checksum.
  always_comb begin
    case (step_r)
      B_HDR_LO: out_byte = HDR_LO;
      B_HDR_HI: out_byte = HDR_HI;
      B_VAL_LO: out_byte = word_r[7:0];
      B_VAL_HI: out_byte = {5'd0, word_r[VAL_W-1:8]};
      B_CS_LO:  out_byte = sum_r[7:0];
      B_CS_HI:  out_byte = sum_r[15:8];
      default:  out_byte = 8'd0;
    endcase
  end

  assign out_last_byte = (step_r == end_step_r);
  assign out_valid     = out_valid_r;
  assign in_ready      = (state_r == S_IDLE);

  `IBCFE_ASSERT_IMPL(a_ready_excl, in_ready, !out_valid)
  `IBCFE_ASSERT_IMPL(a_pos_range, 1'b1, pos_r <= POS_LAST)
  `IBCFE_ASSERT_NEXT(a_accept_mul, in_valid && in_ready, state_r == S_MUL)
  `IBCFE_ASSERT_IMPL(a_div_done_state, div_stat.done, state_r == S_DIV)

endmodule

/* tb/ibus_channel_frame_encoder_tb.sv */
`timescale 1ns / 100ps

module ibus_channel_frame_encoder_tb;
  import ibcfe_pkg::*;

  // The run is stopped as failed once it goes past this many cycles. The slowest
  // correct run is roughly 140 transfers (divider, four bytes with the longest
  // stall each, the longest input gap), plus the drain pauses, and this limit
  // allows for it several times over.
  localparam int CYCLE_LIMIT = 200000;
  // Cycles allowed after the last byte for the block to settle before a register
  // write or the end of the run.
  localparam int SETTLE_CYCLES = 30;

  // One serial byte of the frame as the block should send it.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [VAL_W-1:0] in_channel_value;
  logic             out_valid;
  logic             out_ready;
  logic [7:0]       out_byte;
  logic             out_last_byte;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  // Our own copy of the block's registers and frame state.
  logic [VAL_W-1:0] range_lo;
  logic [VAL_W-1:0] range_hi;
  int unsigned      frame_slot;
  logic [15:0]      frame_sum;

  // Bytes that are owed by the block, oldest first.
  frame_byte_t      owed_bytes[$];

  // Random idling on both sides is switched off for the final stretch.
  bit               idling_on;
  int               ready_hold;
  int unsigned      cycle_count;
  int unsigned      error_count;
  int unsigned      channels_sent;
  int unsigned      bytes_checked;
  int unsigned      frames_done;
  int unsigned      reg_writes;

  ibus_channel_frame_encoder uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_channel_value (in_channel_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last_byte    (out_last_byte),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Linear scaling of a raw channel value onto the servo range, rounded to the
  // nearest step. An empty or inverted input range always gives the minimum.
  function automatic logic [15:0] scale_channel(logic [VAL_W-1:0] raw);
    int unsigned clamped;
    int unsigned span;
    int unsigned scaled;
    if (range_hi <= range_lo) begin
      return 16'(OUT_MIN);
    end
    clamped = raw;
    if (clamped < range_lo) clamped = range_lo;
    if (clamped > range_hi) clamped = range_hi;
    span   = range_hi - range_lo;
    scaled = ((clamped - range_lo) * 2 * (int'(OUT_MAX) - int'(OUT_MIN))) / span
             + 2 * int'(OUT_MIN) + 1;
    return 16'(scaled / 2);
  endfunction

  // Works out the bytes that one accepted channel value causes and queues them.
  // The headers open a frame; the checksum closes it after the last channel.
  task automatic queue_frame_bytes(logic [VAL_W-1:0] raw);
    logic [15:0] word;
    logic [7:0]  step_bytes[$];
    word = scale_channel(raw);
    if (frame_slot == 0) begin
      step_bytes.push_back(HDR_LO);
      step_bytes.push_back(HDR_HI);
    end
    step_bytes.push_back(word[7:0]);
    step_bytes.push_back(word[15:8]);
    frame_sum = frame_sum - {8'h00, word[7:0]} - {8'h00, word[15:8]};
    if (frame_slot >= CHANNELS - 1) begin
      step_bytes.push_back(frame_sum[7:0]);
      step_bytes.push_back(frame_sum[15:8]);
      frame_slot = 0;
      frame_sum  = SUM_RESET;
      frames_done++;
    end else begin
      frame_slot++;
    end
    foreach (step_bytes[i]) begin
      owed_bytes.push_back('{data: step_bytes[i], last: (i == step_bytes.size() - 1)});
    end
  endtask

  // Offers one channel value and returns at the edge where it is transferred.
  // While idling is on, the valid line may first drop for a random burst.
  task automatic send_channel(logic [VAL_W-1:0] raw);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_channel_value <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    queue_frame_bytes(raw);
    channels_sent++;
  endtask

  // Lowers valid, waits for every owed byte and then lets the divider settle.
  task automatic drain_output();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A write on the register port: a setup phase and then an access phase. The
  // register takes the new value at the edge that closes the access phase,
  // and the port then rests before the task returns.
  task automatic write_reg(logic reg_idx, logic [VAL_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_IN_MIN) range_lo = value;
    else range_hi = value;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic set_range(logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi);
    drain_output();
    write_reg(REG_IN_MIN, lo);
    write_reg(REG_IN_MAX, hi);
  endtask

  // Random channel values: half are anywhere in the field, a quarter sit just
  // round either end of the input range and the rest fall inside it (anywhere when it is empty or inverted).
  function automatic logic [VAL_W-1:0] pick_channel();
    int pick;
    int near;
    pick = $urandom_range(0, 3);
    if (pick <= 1) begin
      return VAL_W'($urandom_range(0, 2047));
    end else if (pick == 2) begin
      near = ($urandom_range(0, 1) ? int'(range_lo) : int'(range_hi))
             + int'($urandom_range(0, 6)) - 3;
      if (near < 0) near = 0;
      if (near > 2047) near = 2047;
      return VAL_W'(near);
    end
    if (range_hi <= range_lo) begin
      return VAL_W'($urandom_range(0, 2047));
    end
    return VAL_W'($urandom_range(range_lo, range_hi));
  endfunction

  // A full frame at the reset range, with the field extremes and the values
  // either side of both ends of the range.
  task automatic test_default_frame();
    logic [VAL_W-1:0] picks[$];
    picks = '{11'd0, 11'd2047, 11'd171, 11'd172, 11'd173, 11'd1810, 11'd1811,
              11'd1812, 11'd991, 11'd1024, 11'd1365, 11'd682, 11'd1, 11'd2046};
    foreach (picks[i]) send_channel(picks[i]);
  endtask

  // An empty range and an inverted range both pin every channel to the minimum.
  task automatic test_degenerate_ranges();
    set_range(11'd500, 11'd500);
    send_channel(11'd0);
    send_channel(11'd500);
    send_channel(11'd2047);
    set_range(11'd2047, 11'd0);
    send_channel(11'd1024);
    send_channel(11'd2047);
  endtask

  // The widest range, so the whole field maps onto the output range unclamped.
  task automatic test_full_range();
    set_range(11'd0, 11'd2047);
    send_channel(11'd0);
    send_channel(11'd2047);
    send_channel(11'd1024);
    send_channel(11'd1023);
  endtask

  // Random values under a mix of ranges, fixed extremes among them.
  task automatic test_random_ranges();
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin lo = 11'd172; hi = 11'd1811; end
        1: begin lo = 11'd1000; hi = 11'd1001; end
        2: begin lo = 11'd0; hi = 11'd2047; end
        3: begin lo = 11'd2047; hi = 11'd2047; end
        4: begin
          lo = VAL_W'($urandom_range(1024, 2047));
          hi = VAL_W'($urandom_range(0, 1023));
        end
        default: begin
          lo = VAL_W'($urandom_range(0, 1023));
          hi = VAL_W'($urandom_range(1024, 2047));
        end
      endcase
      set_range(lo, hi);
      repeat (phase == 3 || phase == 4 ? 6 : 14) send_channel(pick_channel());
    end
  endtask

  // The sender stops part way into a frame until every owed byte is out,
  // then carries on with the same frame.
  task automatic test_drain_mid_frame();
    repeat (5) send_channel(pick_channel());
    drain_output();
    repeat (12) send_channel(pick_channel());
  endtask

  // The last stretch runs with valid and ready held high throughout.
  task automatic test_steady_stream();
    set_range(VAL_W'($urandom_range(0, 600)), VAL_W'($urandom_range(1400, 2047)));
    idling_on = 1'b0;
    repeat (30) send_channel(pick_channel());
  endtask

  // Receiver: ready is held or dropped for random bursts while idling is on.
  always @(posedge clk) begin
    if (!idling_on) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready  <= $urandom_range(0, 1);
      ready_hold <= $urandom_range(1, 17);
    end
  end

  // Each transferred byte is checked against the oldest owed byte.
  always @(posedge clk) begin
    frame_byte_t owed;
    if (rst_n && out_valid && out_ready) begin
      if (owed_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, got data %02h last %0b",
                 $time, out_byte, out_last_byte);
        error_count++;
      end else begin
        owed = owed_bytes.pop_front();
        if (out_byte !== owed.data) begin
          $display("%0t: out_byte mismatch: expected %02h, got %02h",
                   $time, owed.data, out_byte);
          error_count++;
        end
        if (out_last_byte !== owed.last) begin
          $display("%0t: out_last_byte mismatch: expected %0b, got %0b",
                   $time, owed.last, out_last_byte);
          error_count++;
        end
      end
      bytes_checked++;
    end
  end

  // Watchdog: a run that hangs is reported as failed.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d bytes still owed",
               cycle_count, owed_bytes.size());
      $display("** ibus_channel_frame_encoder: FAILED **");
      $finish;
    end
  end

  initial begin
    // Every input of the block is known from time zero.
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_channel_value <= '0;
    out_ready        <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    idling_on        = 1'b1;
    ready_hold       = 0;
    cycle_count      = 0;
    error_count      = 0;
    channels_sent    = 0;
    bytes_checked    = 0;
    frames_done      = 0;
    reg_writes       = 0;
    range_lo         = 11'd172;
    range_hi         = 11'd1811;
    frame_slot       = 0;
    frame_sum        = SUM_RESET;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_frame();
    test_degenerate_ranges();
    test_full_range();
    test_random_ranges();
    test_drain_mid_frame();
    test_steady_stream();

    // Every value has been transferred; wait for the remaining bytes and then
    // give the block time to show any stray byte.
    drain_output();

    $display("Sent %0d channel values (%0d complete frames) and checked %0d bytes,",
             channels_sent, frames_done, bytes_checked);
    $display("across %0d register writes covering normal, empty, inverted and full ranges.",
             reg_writes);
    if (error_count == 0 && owed_bytes.size() == 0) begin
      $display("** ibus_channel_frame_encoder: PASSED **");
    end else begin
      $display("** ibus_channel_frame_encoder: FAILED **");
    end
    $finish;
  end

endmodule
